### sv/actr_pkg.sv
// ----------------------------------------------------------------------------
// actr_pkg
// Shared types, constants and AES helper functions for the CTR byte cipher.
// ----------------------------------------------------------------------------
`default_nettype none
package actr_pkg;

  localparam logic [1:0] REG_KEY_HIGH   = 2'd0;
  localparam logic [1:0] REG_KEY_LOW    = 2'd1;
  localparam logic [1:0] REG_NONCE_HIGH = 2'd2;
  localparam logic [1:0] REG_NONCE_LOW  = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       start;
    logic       new_block;
  } item_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_KEY,
    ENG_ROUND
  } eng_state_t;

  function automatic logic [7:0] sbox(input logic [7:0] v);
    logic [7:0] r;
    unique case (v)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
  endfunction

  // Next round constant: doubling in GF(2^8) gives 01..80, 1b, 36.
  function automatic logic [7:0] next_rcon(input logic [7:0] v);
    return xtime(v);
  endfunction

  // Byte i of a 128-bit big-endian block sits in bits 127-8i .. 120-8i.
  function automatic logic [7:0] blk_byte(input logic [127:0] b, input logic [3:0] i);
    return b[8'd127 - {i, 3'b000} -: 8];
  endfunction

  // Next round key from the previous one.
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows and optionally MixColumns; round key added by caller.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        tmp[c*4+i] = sbox(blk_byte(s, 4'(((c + i) & 3) * 4 + i)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = tmp[c*4]; a1 = tmp[c*4+1]; a2 = tmp[c*4+2]; a3 = tmp[c*4+3];
      if (mix) begin
        all = a0 ^ a1 ^ a2 ^ a3;
        r[127-32*c -: 8]  = a0 ^ all ^ xtime(a0 ^ a1);
        r[119-32*c -: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
        r[111-32*c -: 8]  = a2 ^ all ^ xtime(a2 ^ a3);
        r[103-32*c -: 8]  = a3 ^ all ^ xtime(a3 ^ a0);
      end else begin
        r[127-32*c -: 32] = {a0, a1, a2, a3};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/actr_front.sv
// ----------------------------------------------------------------------------
// actr_front
// Accepts bytes, tracks block position and message start, tags each word.
// ----------------------------------------------------------------------------
`default_nettype none
module actr_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     data_byte,
  input  wire logic           last_byte,
  output actr_pkg::item_t     q_item,
  output logic                q_push,
  input  wire logic           q_full
);
  import actr_pkg::*;

  logic       at_start;
  logic [3:0] pos;
  logic       acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc;

  always_comb begin
    q_item.data      = data_byte;
    q_item.last      = last_byte;
    q_item.start     = at_start;
    q_item.new_block = at_start || (pos == 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
      pos      <= 4'd0;
    end else if (acc) begin
      at_start <= last_byte;
      pos      <= (last_byte || at_start) ? (last_byte ? 4'd0 : 4'd1) : pos + 4'd1;
    end
  end

  a_start_pos: assert property (@(posedge clk) disable iff (rst)
    at_start |-> pos == 4'd0) else $error("position not cleared at message start");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (acc && last_byte) |=> (at_start && pos == 4'd0)) else $error("last byte did not restart");
  a_push_acc: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("push into full queue");

endmodule
`default_nettype wire

### sv/actr_queue.sv
// ----------------------------------------------------------------------------
// actr_queue
// Two-entry word queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module actr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire actr_pkg::item_t push_item,
  input  wire logic           push,
  output logic                full,
  output actr_pkg::item_t     pop_item,
  output logic                not_empty,
  input  wire logic           pop
);
  import actr_pkg::*;

  item_t      slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty)) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count out of range");

endmodule
`default_nettype wire

### sv/actr_back.sv
// ----------------------------------------------------------------------------
// actr_back
// Expands keys, encrypts counter blocks one round a cycle, XORs the bytes.
// ----------------------------------------------------------------------------
`default_nettype none
module actr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire actr_pkg::item_t item,
  input  wire logic           item_valid,
  output logic                item_pop,
  input  wire logic [127:0]   key,
  input  wire logic [127:0]   nonce,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          data_out,
  output logic                last_out
);
  import actr_pkg::*;

  eng_state_t state, state_next;
  logic [127:0] rk_mem [11];
  logic [127:0] rk_rd;
  logic [127:0] kexp;
  logic [7:0]   rcon;
  logic [3:0]   step;
  logic [127:0] counter;
  logic [127:0] st;
  logic [127:0] ks;
  logic [3:0]   pos;
  logic         ks_ok;
  logic         out_free;
  logic         emit;
  logic         blk_start;
  logic [3:0]   rd_addr;

  // ks_ok marks a fresh block that still waits for its first byte.
  assign out_free  = !out_valid || out_ready;
  assign blk_start = item_valid && item.new_block && !ks_ok && (state == ENG_IDLE);
  assign emit      = item_valid && (!item.new_block || ks_ok) && (state == ENG_IDLE)
                     && out_free;
  assign item_pop  = emit;

  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: begin
        if (blk_start) state_next = item.start ? ENG_KEY : ENG_ROUND;
      end
      ENG_KEY:   if (step == 4'd9) state_next = ENG_ROUND;
      ENG_ROUND: if (step == 4'd10) state_next = ENG_IDLE;
      default:   state_next = ENG_IDLE;
    endcase
  end

  // The round key for the next round is addressed ahead and registered into rk_rd.
  always_comb begin
    rd_addr = 4'd0;
    if (state == ENG_ROUND && step != 4'd10) rd_addr = step + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (state == ENG_KEY) rk_mem[step + 4'd1] <= key_step(kexp, rcon);
    else if (blk_start && item.start)
      rk_mem[4'd0] <= key;
    rk_rd <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ENG_IDLE;
      step      <= 4'd0;
      ks_ok     <= 1'b0;
      out_valid <= 1'b0;
      pos       <= 4'd0;
    end else begin
      state <= state_next;
      if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ENG_IDLE: begin
          step <= 4'd0;
          if (blk_start) begin
            if (item.start) begin
              kexp    <= key;
              rcon    <= 8'h01;
              counter <= nonce;
            end
          end else if (emit) begin
            out_valid <= 1'b1;
            data_out  <= item.data ^ blk_byte(ks, pos);
            last_out  <= item.last;
            pos       <= pos + 4'd1;
            if (item.new_block) ks_ok <= 1'b0;
          end
        end
        ENG_KEY: begin
          kexp <= key_step(kexp, rcon);
          rcon <= next_rcon(rcon);
          step <= (step == 4'd9) ? 4'd0 : step + 4'd1;
        end
        ENG_ROUND: begin
          if (step == 4'd0) st <= counter ^ rk_rd;
          else st <= aes_round(st, step != 4'd10) ^ rk_rd;
          if (step == 4'd10) begin
            ks      <= aes_round(st, 1'b0) ^ rk_rd;
            ks_ok   <= 1'b1;
            pos     <= 4'd0;
            counter <= counter + 128'd1;
            step    <= 4'd0;
          end else begin
            step <= step + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Step zero of ROUND needs rk[0] which was addressed in the prior cycle;
  // rd_addr defaults to 0 outside ROUND so it is ready.

  a_emit_ks: assert property (@(posedge clk) disable iff (rst)
    (emit && item.new_block) |-> ks_ok) else $error("byte emitted without keystream");
  a_ks_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ENG_ROUND && step == 4'd10) |=> ks_ok && state == ENG_IDLE)
    else $error("keystream not marked ready");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(data_out))
    else $error("stalled result changed");

endmodule
`default_nettype wire

### sv/aes128_ctr_byte_cipher_core.sv
// The first byte of a message waits for 10 key steps and 11 rounds, then the
// queue and output register; the first byte of each further block waits for
// its 11 rounds. Throughput: one byte a cycle inside a block while out_ready
// holds; each block is encrypted in the single round unit of the back end.
// Reset: synchronous, active high; control and config registers clear, next byte
// starts a message. Round key memory is undefined until the first message start.
// ----------------------------------------------------------------------------
// aes128_ctr_byte_cipher_core
// AES-128 counter-mode byte cipher: front classifier, queue, round engine.
// ----------------------------------------------------------------------------
`default_nettype none
module aes128_ctr_byte_cipher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       data_out,
  output logic             last_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import actr_pkg::*;

  logic [63:0] key_high, key_low, nonce_high, nonce_low;
  item_t push_item, pop_item;
  logic  push, full, not_empty, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0; key_low <= '0; nonce_high <= '0; nonce_low <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_HIGH:   key_high   <= cfg_data;
        REG_KEY_LOW:    key_low    <= cfg_data;
        REG_NONCE_HIGH: nonce_high <= cfg_data;
        REG_NONCE_LOW:  nonce_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  actr_front u_front (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .last_byte,
    .q_item(push_item), .q_push(push), .q_full(full)
  );

  actr_queue u_queue (
    .clk, .rst, .push_item, .push, .full, .pop_item, .not_empty, .pop
  );

  actr_back u_back (
    .clk, .rst, .item(pop_item), .item_valid(not_empty), .item_pop(pop),
    .key({key_high, key_low}), .nonce({nonce_high, nonce_low}),
    .out_valid, .out_ready, .data_out, .last_out
  );

endmodule
`default_nettype wire
